FILE: hw/rtl/jss_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the jacobi stencil sweep block
// no dependencies; imported by the result fifo and the top level

package jss_pkg;

    // fixed field widths of the result transaction
    localparam int COL_BITS = 10;
    localparam int ROW_BITS = 16;

    // configuration register widths
    localparam int GRID_W_BITS   = 11;
    localparam int GRID_H_BITS   = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_ADDR_BITS = 1;

    // smallest grid dimension the sweep works on
    localparam int MIN_DIM = 3;

    localparam logic [GRID_W_BITS-1:0] GRID_W_RESET = 11'd1024;
    localparam logic [GRID_H_BITS-1:0] GRID_H_RESET = 16'd1024;

    // result queue geometry
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_PTR_BITS = 3;
    localparam int FIFO_CNT_BITS = 4;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } t_cfg_reg;

endpackage

FILE: hw/rtl/jss_window_cell.sv
`timescale 1ns / 1ps
// one cell of the stencil window chain: holds a sample and passes it on
// no dependencies; instantiated in a chain by the top level

module jss_window_cell #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_shift,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);

    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [SAMPLE_BITS-1:0] n_sample;

    // take the neighbour's value on every accepted transaction; a clear zeroes it first
    always_comb begin
        n_sample = r_sample;
        if (i_clear) begin
            n_sample = '0;
        end else if (i_shift) begin
            n_sample = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else begin
            r_sample <= n_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

FILE: hw/rtl/jss_line_ram.sv
`timescale 1ns / 1ps
// line store: one write port, one read port with registered read data
// no dependencies; holds the two previous rows for the top level

module jss_line_ram #(
    parameter int DEPTH     = 1024,
    parameter int WIDTH     = 64,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/jss_result_fifo.sv
`timescale 1ns / 1ps
// small result queue: up to two pushes and one pop per cycle
// depends on jss_pkg for its depth and pointer widths

module jss_result_fifo #(
    parameter int WIDTH = 59
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_n,
    input  logic [WIDTH-1:0] i_data0,
    input  logic [WIDTH-1:0] i_data1,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    import jss_pkg::*;

    logic [WIDTH-1:0]         r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wptr;
    logic [FIFO_PTR_BITS-1:0] r_rptr;
    logic [FIFO_CNT_BITS-1:0] r_cnt;
    logic [FIFO_PTR_BITS-1:0] wptr_next1;
    logic                     pop;

    assign pop        = o_valid && i_ready;
    assign wptr_next1 = r_wptr + FIFO_PTR_BITS'(1);

    // storage: first result at the write pointer, second just after it
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wptr] <= i_data0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wptr_next1] <= i_data1;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= r_wptr + FIFO_PTR_BITS'(i_push_n);
            r_rptr <= r_rptr + FIFO_PTR_BITS'(pop);
            r_cnt  <= r_cnt + FIFO_CNT_BITS'(i_push_n) - FIFO_CNT_BITS'(pop);
        end
    end

    // room for one result stage in flight plus one new input
    assign o_room  = (r_cnt <= FIFO_CNT_BITS'(FIFO_DEPTH - 4));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];

endmodule

FILE: hw/rtl/jacobi_stencil_sweep_2d_top.sv
`timescale 1ns / 1ps
// top level of the jacobi 5-point stencil sweep over a raster-order grid
// depends on jss_pkg, jss_line_ram, jss_window_cell and jss_result_fifo

// One Jacobi sweep of a 5-point stencil over a grid streamed in raster order,
// one signed fixed-point sample per transaction. The sample at (column c,
// row r) with r >= 1 produces cell (c, r-1): interior cells get the floor of
// the average of their four neighbours, border cells pass through. Row 0
// produces nothing; samples of the last row also produce their own cell, so
// the last row yields two results per sample. The block takes one sample per
// clock while the result queue has room; on the last row the output port,
// which delivers one result per clock while the receiver is ready, paces it.
// Each result passes stage a and the result queue on its way out. The two previous
// rows live in one line store read two columns ahead, so no clearing pass
// follows reset. Any configuration write restarts the grid at column 0, row 0.

module jacobi_stencil_sweep_2d_top #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [jss_pkg::CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [jss_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    // sample stream in
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // sample
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // result stream out
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // column, row, value
    output logic [((jss_pkg::COL_BITS + jss_pkg::ROW_BITS + SAMPLE_BITS + 7) / 8) * 8 - 1:0]
                                               o_m_axis_tdata,
    // frame_last
    output logic                               o_m_axis_tlast
);

    import jss_pkg::*;

    localparam int CW             = $clog2(MAX_WIDTH);
    localparam int OUT_TDATA_BITS = ((COL_BITS + ROW_BITS + SAMPLE_BITS + 7) / 8) * 8;
    localparam int RES_BITS       = COL_BITS + ROW_BITS + SAMPLE_BITS + 1;

    // configuration registers
    logic [GRID_W_BITS-1:0] r_grid_width;
    logic [GRID_H_BITS-1:0] r_grid_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_W_RESET;
            r_grid_height <= GRID_H_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_GRID_WIDTH: begin
                    r_grid_width <= i_cfg_wdata[GRID_W_BITS-1:0];
                end
                CFG_GRID_HEIGHT: begin
                    r_grid_height <= i_cfg_wdata[GRID_H_BITS-1:0];
                end
            endcase
        end
    end

    // effective grid limits after clamping
    logic [31:0]            w_clamp;
    logic [CW-1:0]          col_last;
    logic [GRID_H_BITS-1:0] row_last;

    always_comb begin
        if (32'(r_grid_width) < 32'(MIN_DIM)) begin
            w_clamp = 32'(MIN_DIM);
        end else if (32'(r_grid_width) > 32'(MAX_WIDTH)) begin
            w_clamp = 32'(MAX_WIDTH);
        end else begin
            w_clamp = 32'(r_grid_width);
        end
        col_last = CW'(w_clamp - 32'd1);
        if (r_grid_height < GRID_H_BITS'(MIN_DIM)) begin
            row_last = GRID_H_BITS'(MIN_DIM - 1);
        end else begin
            row_last = r_grid_height - GRID_H_BITS'(1);
        end
    end

    // input transaction
    logic                          in_acc;
    logic                          fifo_room;
    logic signed [SAMPLE_BITS-1:0] x;

    assign o_s_axis_tready = fifo_room;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign x               = signed'(i_s_axis_tdata[SAMPLE_BITS-1:0]);

    // raster position of the next sample
    logic [CW-1:0]          r_col;
    logic [GRID_H_BITS-1:0] r_row;
    logic [CW-1:0]          n_col;
    logic [GRID_H_BITS-1:0] n_row;
    logic                   col_end;
    logic                   row_end;

    assign col_end = (r_col == col_last);
    assign row_end = (r_row == row_last);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cfg_we) begin
            n_col = '0;
            n_row = '0;
        end else if (in_acc) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + GRID_H_BITS'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line store read runs two columns ahead, wrapping into the next row
    logic [CW-1:0] rd_addr;

    always_comb begin
        if (col_end) begin
            rd_addr = CW'(1);
        end else if (r_col == col_last - CW'(1)) begin
            rd_addr = '0;
        end else begin
            rd_addr = r_col + CW'(2);
        end
    end

    // line store: upper half older row, lower half previous row
    logic [2*SAMPLE_BITS-1:0]      ram_rdata;
    logic signed [SAMPLE_BITS-1:0] rd_prev;
    logic signed [SAMPLE_BITS-1:0] rd_old;
    logic signed [SAMPLE_BITS-1:0] cen_prev;
    logic signed [SAMPLE_BITS-1:0] left_prev;
    logic signed [SAMPLE_BITS-1:0] cen_old;

    jss_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (2 * SAMPLE_BITS)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_col),
        .i_wdata ({cen_prev, x}),
        .i_re    (in_acc),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_prev = signed'(ram_rdata[SAMPLE_BITS-1:0]);
    assign rd_old  = signed'(ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);

    // window chain: right (line store) -> centre -> left, and the row above
    jss_window_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell_centre (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (i_cfg_we),
        .i_shift  (in_acc),
        .i_sample (rd_prev),
        .o_sample (cen_prev)
    );

    jss_window_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (i_cfg_we),
        .i_shift  (in_acc),
        .i_sample (cen_prev),
        .o_sample (left_prev)
    );

    jss_window_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell_up (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (i_cfg_we),
        .i_shift  (in_acc),
        .i_sample (rd_old),
        .o_sample (cen_old)
    );

    // stage a: capture the stencil and form the pairwise sums
    logic                          r_a_vld;
    logic                          r_a_emit_up;
    logic                          r_a_emit_own;
    logic                          r_a_border;
    logic                          r_a_last;
    logic [CW-1:0]                 r_a_col;
    logic [GRID_H_BITS-1:0]        r_a_row;
    logic signed [SAMPLE_BITS-1:0] r_a_center;
    logic signed [SAMPLE_BITS-1:0] r_a_x;
    logic signed [SAMPLE_BITS:0]   r_a_sum_ul;
    logic signed [SAMPLE_BITS:0]   r_a_sum_rx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_emit_up  <= (r_row != '0);
            r_a_emit_own <= row_end;
            r_a_border   <= (r_row == GRID_H_BITS'(1)) || (r_col == '0) || col_end;
            r_a_last     <= col_end;
            r_a_col      <= r_col;
            r_a_row      <= r_row;
            r_a_center   <= cen_prev;
            r_a_x        <= x;
            r_a_sum_ul   <= {cen_old[SAMPLE_BITS-1], cen_old}
                          + {left_prev[SAMPLE_BITS-1], left_prev};
            r_a_sum_rx   <= {rd_prev[SAMPLE_BITS-1], rd_prev}
                          + {x[SAMPLE_BITS-1], x};
        end
    end

    // stage b: final sum, floor divide by four, build the results
    logic signed [SAMPLE_BITS+1:0] sum_all;
    logic signed [SAMPLE_BITS-1:0] val_up;
    logic [RES_BITS-1:0]           res_up;
    logic [RES_BITS-1:0]           res_own;
    logic [1:0]                    push_n;
    logic [RES_BITS-1:0]           push_data0;

    assign sum_all = {r_a_sum_ul[SAMPLE_BITS], r_a_sum_ul}
                   + {r_a_sum_rx[SAMPLE_BITS], r_a_sum_rx};
    assign val_up  = r_a_border ? r_a_center : signed'(sum_all[SAMPLE_BITS+1:2]);

    assign res_up  = {1'b0, val_up, ROW_BITS'(r_a_row - GRID_H_BITS'(1)),
                      COL_BITS'(r_a_col)};
    assign res_own = {r_a_last, r_a_x, ROW_BITS'(r_a_row), COL_BITS'(r_a_col)};

    assign push_n     = r_a_vld ? ({1'b0, r_a_emit_up} + {1'b0, r_a_emit_own}) : 2'd0;
    assign push_data0 = r_a_emit_up ? res_up : res_own;

    // result queue to the output port
    logic [RES_BITS-1:0] fifo_data;

    jss_result_fifo #(.WIDTH(RES_BITS)) u_result_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_data0  (push_data0),
        .i_data1  (res_own),
        .o_room   (fifo_room),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (fifo_data)
    );

    assign o_m_axis_tdata = OUT_TDATA_BITS'(fifo_data[RES_BITS-2:0]);
    assign o_m_axis_tlast = fifo_data[RES_BITS-1];

endmodule
